// ===== rtl/rdpd_pkg.sv =====
// ----------------------------------------------------------------------------
// rdpd_pkg
// Shared constants and types for the ramped delay pitch-down block.
// ----------------------------------------------------------------------------
package rdpd_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    // Delay in half samples spans -1 .. 2*STORE_DEPTH-2, plus a sign bit.
    localparam int DELAY_W     = ADDR_W + 2;
    localparam int SAMPLE_W    = 16;

    typedef logic        [ADDR_W-1:0]   addr_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [DELAY_W-1:0]  delay_t;

endpackage

// ===== rtl/rdpd_store.sv =====
// ----------------------------------------------------------------------------
// rdpd_store
// Circular sample store with one write port and two registered read ports.
// Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module rdpd_store (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  rdpd_pkg::sample_t wr_data,
    input  rdpd_pkg::addr_t   rd_addr_a,
    input  rdpd_pkg::addr_t   rd_addr_b,
    output rdpd_pkg::addr_t   wr_index,
    output rdpd_pkg::sample_t rd_data_a,
    output rdpd_pkg::sample_t rd_data_b
);
    import rdpd_pkg::*;

    localparam addr_t LAST_ADDR = addr_t'(STORE_DEPTH - 1);

    sample_t mem [STORE_DEPTH];

    addr_t   wr_ptr_reg;
    addr_t   wr_ptr_next;
    logic    wrapped_reg;
    logic    wrapped_next;
    sample_t data_a_reg;
    sample_t data_b_reg;
    logic    ok_a_reg;
    logic    ok_b_reg;
    logic    ok_a_next;
    logic    ok_b_next;

    // An entry holds real data once the pointer has passed it or wrapped.
    always_comb
    begin
        ok_a_next    = wrapped_reg || (rd_addr_a < wr_ptr_reg);
        ok_b_next    = wrapped_reg || (rd_addr_b < wr_ptr_reg);
        wr_ptr_next  = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + addr_t'(1);
        wrapped_next = wrapped_reg || (wr_ptr_reg == LAST_ADDR);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a_reg      <= mem[rd_addr_a];
            data_b_reg      <= mem[rd_addr_b];
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            wrapped_reg <= 1'b0;
            ok_a_reg    <= 1'b0;
            ok_b_reg    <= 1'b0;
        end
        else if (en)
        begin
            wr_ptr_reg  <= wr_ptr_next;
            wrapped_reg <= wrapped_next;
            ok_a_reg    <= ok_a_next;
            ok_b_reg    <= ok_b_next;
        end
    end

    assign wr_index  = wr_ptr_reg;
    assign rd_data_a = ok_a_reg ? data_a_reg : '0;
    assign rd_data_b = ok_b_reg ? data_b_reg : '0;

endmodule

// ===== rtl/ramped_delay_pitch_down.sv =====
// ----------------------------------------------------------------------------
// ramped_delay_pitch_down
// Mono pitch-down effect on a variable delay line with half-sample averaging.
// ----------------------------------------------------------------------------
// Pipeline: taps registered in the store, then the result in sample_out_reg.
// Throughput: one sample per cycle without output stalls; the store reads both
//   taps and writes the new sample in the same cycle: back-to-back flow.
// Reset: rst_n clears pointer, delay and pipeline valids at once. The store
//   is not cleared; a fill flag makes unwritten entries read as zero, so no
//   clearing pass is needed and in_ready is high right after reset.
// ----------------------------------------------------------------------------
module ramped_delay_pitch_down (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rdpd_pkg::sample_t sample_in,
    output logic              out_valid,
    input  logic              out_ready,
    output rdpd_pkg::sample_t sample_out
);
    import rdpd_pkg::*;

    localparam delay_t DEPTH_D   = delay_t'(STORE_DEPTH);
    localparam delay_t DELAY_MAX = delay_t'(2 * (STORE_DEPTH - 1));
    // 2*STORE_DEPTH may not fit the signed width; subtraction is modulo the
    // width, so the wrapped delay still comes out right.
    localparam delay_t DELAY_SPAN = delay_t'(2 * STORE_DEPTH);
    localparam addr_t  LAST_ADDR  = addr_t'(STORE_DEPTH - 1);

    // Delay state, advanced once per input transfer.
    delay_t delay_reg;
    delay_t delay_next;
    delay_t delay_inc;

    // Read-stage control travels with the registered store data.
    logic   s1_valid_reg;
    logic   s1_valid_next;
    logic   half_reg;

    // Result register.
    logic    out_valid_reg;
    sample_t sample_out_reg;
    sample_t result;

    logic   accept;
    logic   s1_advance;

    delay_t whole;
    delay_t diff;
    addr_t  rd_addr;
    addr_t  nx_addr;
    addr_t  wr_index;

    sample_t tap_a;
    sample_t tap_b;
    logic signed [SAMPLE_W:0] tap_sum;

    // ------------------------------------------------------------------------
    // Handshake: the read stage moves on when the result register is empty
    // or being drained; a new sample enters whenever the read stage frees up.
    // ------------------------------------------------------------------------
    assign s1_advance = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign accept     = in_valid && in_ready;

    // ------------------------------------------------------------------------
    // Read address: write pointer minus the whole part of the delay, wrapped
    // into the store. The whole part spans -1 .. STORE_DEPTH-1, so one
    // correction in either direction is enough.
    // ------------------------------------------------------------------------
    always_comb
    begin
        whole = delay_reg >>> 1;
        diff  = delay_t'({2'b00, wr_index}) - whole;
        if (diff < 0)
        begin
            rd_addr = addr_t'(diff + DEPTH_D);
        end
        else if (diff >= DEPTH_D)
        begin
            rd_addr = addr_t'(diff - DEPTH_D);
        end
        else
        begin
            rd_addr = addr_t'(diff);
        end
        nx_addr = (rd_addr == LAST_ADDR) ? '0 : rd_addr + addr_t'(1);
    end

    // ------------------------------------------------------------------------
    // Delay ramp: grow by one half sample, drop by a full store past the top.
    // ------------------------------------------------------------------------
    always_comb
    begin
        delay_inc = delay_reg + delay_t'(1);
        if (delay_inc > DELAY_MAX)
        begin
            delay_next = delay_inc - DELAY_SPAN;
        end
        else
        begin
            delay_next = delay_inc;
        end
    end

    // Store: reads see the contents before this transfer's write.
    rdpd_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (accept),
        .wr_data   (sample_in),
        .rd_addr_a (rd_addr),
        .rd_addr_b (nx_addr),
        .wr_index  (wr_index),
        .rd_data_a (tap_a),
        .rd_data_b (tap_b)
    );

    // ------------------------------------------------------------------------
    // Interpolate: on a half-sample delay, average the two taps with a
    // floored arithmetic shift; the sum's top bits always fit the sample.
    // ------------------------------------------------------------------------
    always_comb
    begin
        tap_sum = {tap_a[SAMPLE_W-1], tap_a} + {tap_b[SAMPLE_W-1], tap_b};
        if (half_reg)
        begin
            result = tap_sum[SAMPLE_W:1];
        end
        else
        begin
            result = tap_a;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                delay_reg <= delay_next;
            end
            if (s1_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload: hold while stalled.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            half_reg <= delay_reg[0];
        end
        if (s1_advance && s1_valid_reg)
        begin
            sample_out_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

endmodule

// ===== rtl/rdpd_checker.sv =====
// ----------------------------------------------------------------------------
// rdpd_checker
// Port-level checks for ramped_delay_pitch_down, bound to the top level.
// ----------------------------------------------------------------------------
module rdpd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input rdpd_pkg::sample_t sample_in,
    input logic              out_valid,
    input logic              out_ready,
    input rdpd_pkg::sample_t sample_out
);
    // The result side stays empty in the first cycle after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

    // Input stalls only when a result is waiting and not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output backpressure");

    // With an empty result register the block must take a new sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready while output empty");

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(sample_out)))
        else $error("stalled result changed");

    // A waiting input sample holds until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |=> (in_valid && $stable(sample_in)))
        else $error("waiting input changed");

endmodule

bind ramped_delay_pitch_down rdpd_checker u_rdpd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
);
